// File: hw/rtl/gkn_pkg.sv
// ----------------------------------------------------------------------------
// gkn_pkg: shared types and constants of the greedy ratio knapsack
// Field widths, memory entry layout, and the command/status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package gkn_pkg;

	localparam int WeightW = 16;
	localparam int ValueW  = 16;
	localparam int RatioW  = 16;
	localparam int CapW    = 24;
	localparam int DivCntW = 4;
	localparam int DivSteps = 16;

	// one stored item: ratio above weight
	typedef struct packed {
		logic [RatioW-1:0]  ratio;
		logic [WeightW-1:0] weight;
	} entry_t;

	// source of the memory write data
	typedef enum logic [1:0] {
		WSRC_LOAD  = 2'd0,
		WSRC_CMP   = 2'd1,
		WSRC_CARRY = 2'd2
	} wsrc_t;

	// controller to datapath commands
	typedef struct packed {
		logic  div_start;
		logic  wr_en;
		wsrc_t wr_src;
		logic  rd_en;
		logic  carry_ld;
		logic  cmp_step;
		logic  tot_clr;
		logic  tot_add;
		logic  out_load;
		logic  out_dropped;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic div_done;
		logic fits;
	} dp_sts_t;

endpackage

// File: hw/rtl/gkn_div.sv
// ----------------------------------------------------------------------------
// gkn_div: 16-bit restoring divider
// One quotient bit per cycle from start to done. A zero
// divisor yields an all-ones quotient, which is the maximum ratio.
// ----------------------------------------------------------------------------
module gkn_div
	import gkn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ValueW-1:0] dividend,
	input  logic [WeightW-1:0] divisor,
	output logic              done,
	output logic [RatioW-1:0] quotient
);

	logic               busy_q;
	logic               done_q;
	logic [DivCntW-1:0] step_q;
	logic [WeightW-1:0] rem_q;
	logic [ValueW-1:0]  quo_q;
	logic [WeightW-1:0] den_q;

	logic [WeightW:0]   shifted;
	logic [WeightW+1:0] diff;
	logic               ge;
	logic [WeightW-1:0] rem_next;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		shifted  = {rem_q, quo_q[ValueW-1]};
		diff     = {1'b0, shifted} - {2'b00, den_q};
		ge       = !diff[WeightW+1];
		rem_next = ge ? diff[WeightW-1:0] : shifted[WeightW-1:0];
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + DivCntW'(1);
				if (step_q == DivCntW'(DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[ValueW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: hw/rtl/gkn_dp.sv
// ----------------------------------------------------------------------------
// gkn_dp: datapath of the greedy ratio knapsack
// Item memory, ratio divider, bubble-pass carry register, running total,
// capacity register and result registers.
// ----------------------------------------------------------------------------
module gkn_dp
	import gkn_pkg::*;
#(
	parameter int MAX_ITEMS = 64,
	localparam int AW = $clog2(MAX_ITEMS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [CapW-1:0]    cfg_data,
	input  logic [WeightW-1:0] item_weight,
	input  logic [ValueW-1:0]  item_value,
	input  dp_cmd_t            cmd,
	input  logic [AW-1:0]      wr_addr,
	input  logic [AW-1:0]      rd_addr,
	output dp_sts_t            sts,
	output logic [CapW-1:0]    packed_weight,
	output logic               items_dropped
);

	entry_t mem_q [MAX_ITEMS];
	entry_t rdata_q;
	entry_t carry_q;
	entry_t wdata;

	logic [CapW-1:0]    cap_q;
	logic [WeightW-1:0] weight_q;
	logic [CapW-1:0]    total_q;
	logic [CapW-1:0]    packed_q;
	logic               dropped_q;
	logic [CapW:0]      next_sum;
	logic               swap;
	logic               div_done;
	logic [RatioW-1:0]  quotient;

	gkn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (item_value),
		.divisor  (item_weight),
		.done     (div_done),
		.quotient (quotient)
	);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// swap only on a strictly larger ratio, which keeps the sort stable
	assign swap = carry_q.ratio < rdata_q.ratio;

	// select the write data
	always_comb begin
		case (cmd.wr_src)
			WSRC_LOAD:  wdata = '{ratio: quotient, weight: weight_q};
			WSRC_CMP:   wdata = swap ? rdata_q : carry_q;
			WSRC_CARRY: wdata = carry_q;
			default:    wdata = carry_q;
		endcase
	end

	// item memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// running total against capacity
	assign next_sum = {1'b0, total_q} + (CapW+1)'(rdata_q.weight);
	assign sts.fits = next_sum <= {1'b0, cap_q};
	assign sts.div_done = div_done;

	// hold weight, carry, total and result
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			weight_q <= item_weight;
		end
		if (cmd.carry_ld) begin
			carry_q <= rdata_q;
		end else if (cmd.cmp_step && !swap) begin
			carry_q <= rdata_q;
		end
		if (cmd.tot_clr) begin
			total_q <= '0;
		end else if (cmd.tot_add && sts.fits) begin
			total_q <= next_sum[CapW-1:0];
		end
		if (cmd.out_load) begin
			packed_q  <= total_q;
			dropped_q <= cmd.out_dropped;
		end
	end

	assign packed_weight = packed_q;
	assign items_dropped = dropped_q;

endmodule

// File: hw/rtl/gkn_ctrl.sv
// ----------------------------------------------------------------------------
// gkn_ctrl: controller of the greedy ratio knapsack
// Sequences load, bubble-sort passes and the greedy walk, keeps the item
// count and drop flag, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module gkn_ctrl
	import gkn_pkg::*;
#(
	parameter int MAX_ITEMS = 64,
	localparam int AW = $clog2(MAX_ITEMS),
	localparam int CW = $clog2(MAX_ITEMS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last_item,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output dp_cmd_t       cmd,
	input  dp_sts_t       sts,
	output logic [AW-1:0] wr_addr,
	output logic [AW-1:0] rd_addr
);

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_DIV      = 11'b000_0000_0010,
		S_SRT_INIT = 11'b000_0000_0100,
		S_SRT_CAP  = 11'b000_0000_1000,
		S_SRT_RD   = 11'b000_0001_0000,
		S_SRT_CMP  = 11'b000_0010_0000,
		S_SRT_END  = 11'b000_0100_0000,
		S_FIL_INIT = 11'b000_1000_0000,
		S_FIL_RD   = 11'b001_0000_0000,
		S_FIL_ADD  = 11'b010_0000_0000,
		S_DONE     = 11'b100_0000_0000
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          last_q;
	logic [AW-1:0] end_q;
	logic [AW-1:0] idx_q;
	logic          out_valid_q;

	logic          full;
	logic          out_free;
	logic          fill_last;
	logic [AW-1:0] idx_inc;

	assign full      = count_q == CW'(MAX_ITEMS);
	assign out_free  = !out_valid_q || !out_stall;
	assign idx_inc   = idx_q + AW'(1);
	assign fill_last = (CW'(idx_q) + CW'(1)) == count_q;
	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	// decode commands and memory addresses
	always_comb begin
		cmd         = '0;
		cmd.wr_src  = WSRC_CARRY;
		wr_addr     = idx_q;
		rd_addr     = idx_q;
		case (state_q)
			S_IDLE: begin
				cmd.div_start = in_valid && !full;
			end
			S_DIV: begin
				cmd.wr_en  = sts.div_done;
				cmd.wr_src = WSRC_LOAD;
				wr_addr    = count_q[AW-1:0];
			end
			S_SRT_INIT: begin
				cmd.rd_en = 1'b1;
				rd_addr   = '0;
			end
			S_SRT_CAP: begin
				cmd.carry_ld = 1'b1;
			end
			S_SRT_RD: begin
				cmd.rd_en = 1'b1;
				rd_addr   = idx_inc;
			end
			S_SRT_CMP: begin
				cmd.cmp_step = 1'b1;
				cmd.wr_en    = 1'b1;
				cmd.wr_src   = WSRC_CMP;
			end
			S_SRT_END: begin
				cmd.wr_en = 1'b1;
				wr_addr   = end_q;
			end
			S_FIL_INIT: begin
				cmd.tot_clr = 1'b1;
			end
			S_FIL_RD: begin
				cmd.rd_en = 1'b1;
			end
			S_FIL_ADD: begin
				cmd.tot_add = 1'b1;
			end
			S_DONE: begin
				cmd.out_load    = out_free;
				cmd.out_dropped = ovf_q;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
			end_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q <= last_item;
						if (!full) begin
							state_q <= S_DIV;
						end else begin
							// store full: drop the beat, still close the set on last
							ovf_q <= 1'b1;
							if (last_item) begin
								end_q   <= AW'(MAX_ITEMS - 1);
								state_q <= S_SRT_INIT;
							end
						end
					end
				end
				S_DIV: begin
					if (sts.div_done) begin
						count_q <= count_q + CW'(1);
						if (last_q) begin
							end_q   <= count_q[AW-1:0];
							state_q <= (count_q == '0) ? S_FIL_INIT : S_SRT_INIT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SRT_INIT: begin
					idx_q   <= '0;
					state_q <= S_SRT_CAP;
				end
				S_SRT_CAP: begin
					state_q <= S_SRT_RD;
				end
				S_SRT_RD: begin
					state_q <= S_SRT_CMP;
				end
				S_SRT_CMP: begin
					idx_q   <= idx_inc;
					state_q <= (idx_inc == end_q) ? S_SRT_END : S_SRT_RD;
				end
				S_SRT_END: begin
					// each pass settles the smallest ratio at the end
					end_q   <= end_q - AW'(1);
					state_q <= (end_q == AW'(1)) ? S_FIL_INIT : S_SRT_INIT;
				end
				S_FIL_INIT: begin
					idx_q   <= '0;
					state_q <= S_FIL_RD;
				end
				S_FIL_RD: begin
					state_q <= S_FIL_ADD;
				end
				S_FIL_ADD: begin
					if (!sts.fits || fill_last) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_FIL_RD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// a new result never overwrites one still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a stalled beat");

	// a loaded result is offered in the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");

	// the item count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ITEMS))
		else $error("item count beyond store depth");

	// a sort compare stays inside the unsorted part
	a_cmp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRT_CMP) |-> (idx_q < end_q))
		else $error("sort compare beyond pass end");

	// the divider finishes only while a load waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == S_DIV))
		else $error("divider done outside load");

endmodule

// File: hw/rtl/greedy_ratio_knapsack.sv
// ----------------------------------------------------------------------------
// greedy_ratio_knapsack: greedy knapsack fill by value/weight ratio
// Loads a set of items, sorts them by descending ratio and packs weights
// into the capacity until the first item that does not fit.
// ----------------------------------------------------------------------------
// Usage:
//   Write capacity on the cfg channel (cfg_ready is always high) while idle.
//   Send items on the input channel, one beat each; the beat with last_item
//   closes the set. A beat past MAX_ITEMS is dropped and flags items_dropped.
//   Each stored item is accepted, runs the 16 steps of the ratio divider and
//   is written to memory; in_stall stays high meanwhile. A dropped beat does
//   not raise in_stall. After the last beat the set is sorted by bubble
//   passes: each pass reads the first entry into the carry register, then
//   reads and compares each following entry, writing back the larger ratio,
//   and writes the carry to the pass end. The walk then reads items until one
//   does not fit, and the result register is loaded.
//   The result (packed_weight, items_dropped) sits in an output register;
//   new items are taken while it waits. Should the next set finish while
//   out_stall still holds the old beat, the block waits before its result.
//   Reset clears capacity, the count, the drop flag and the output valid;
//   the item memory needs no clearing.
// ----------------------------------------------------------------------------
module greedy_ratio_knapsack
	import gkn_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CapW-1:0]    cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [WeightW-1:0] item_weight,
	input  logic [ValueW-1:0]  item_value,
	input  logic               last_item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CapW-1:0]    packed_weight,
	output logic               items_dropped
);

	localparam int AW = $clog2(MAX_ITEMS);

	dp_cmd_t       cmd;
	dp_sts_t       sts;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	assign cfg_ready = 1'b1;

	gkn_ctrl #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_item (last_item),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr)
	);

	gkn_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.item_weight   (item_weight),
		.item_value    (item_value),
		.cmd           (cmd),
		.wr_addr       (wr_addr),
		.rd_addr       (rd_addr),
		.sts           (sts),
		.packed_weight (packed_weight),
		.items_dropped (items_dropped)
	);

endmodule

// File: test/tb_greedy_ratio_knapsack.sv
// ----------------------------------------------------------------------------
// tb_greedy_ratio_knapsack: self-checking bench of the greedy ratio knapsack
// Feeds item sets (small, mid-size, full and overflowing) under several
// capacity settings, with random gaps on the input and random stalls on the
// output. An in-bench model stores, sorts and packs each set and every
// result beat is checked against its prediction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_greedy_ratio_knapsack
	import gkn_pkg::*;
();

	localparam int MAX_ITEMS = 64;
	localparam int SETTLE    = 64;       // idle cycles before a capacity write
	localparam int ITEMS     = 1400;     // random items to send

	typedef enum logic [1:0] {
		STEP_ITEM  = 2'd0,
		STEP_CAP   = 2'd1,
		STEP_DRAIN = 2'd2
	} step_kind_t;

	typedef struct {
		step_kind_t         kind;
		logic [WeightW-1:0] weight;
		logic [ValueW-1:0]  value;
		logic               last;
		logic [CapW-1:0]    cap;
	} load_step_t;

	typedef struct {
		logic [CapW-1:0] packed_w;
		logic            dropped;
	} knap_fill_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CapW-1:0]    cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [WeightW-1:0] item_weight = '0;
	logic [ValueW-1:0]  item_value = '0;
	logic               last_item = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [CapW-1:0]    packed_weight;
	logic               items_dropped;

	load_step_t  load_q[$];
	knap_fill_t  fill_q[$];
	load_step_t  spent_step;

	// model state
	logic [WeightW-1:0] stow_weight [MAX_ITEMS];
	logic [RatioW-1:0]  stow_ratio [MAX_ITEMS];
	int unsigned        stow_count = 0;
	logic               stow_overflow = 1'b0;
	logic [CapW-1:0]    model_capacity = '0;

	int unsigned error_count = 0;
	int unsigned beats_sent = 0;
	int unsigned fills_seen = 0;
	int unsigned settle_cnt = 0;
	int unsigned random_items = 0;
	logic        nxt_in_valid;
	logic        nxt_cfg_valid;

	greedy_ratio_knapsack #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.item_weight  (item_weight),
		.item_value   (item_value),
		.last_item    (last_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.packed_weight(packed_weight),
		.items_dropped(items_dropped)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// hard stop far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	// store one item, and on the last one sort, pack and queue the fill
	function automatic void stow_item(input logic [WeightW-1:0] w,
			input logic [ValueW-1:0] v, input logic last);
		logic [RatioW-1:0]  t_r;
		logic [WeightW-1:0] t_w;
		int unsigned        total;
		int unsigned        nxt;
		int unsigned        pass;
		int unsigned        j;
		knap_fill_t         fill;
		if (stow_count < MAX_ITEMS) begin
			stow_weight[stow_count] = w;
			stow_ratio[stow_count] = (w == '0) ? {RatioW{1'b1}} : RatioW'(v / w);
			stow_count++;
		end else begin
			stow_overflow = 1'b1;
		end
		if (last) begin
			// stable bubble sort, descending ratio
			for (pass = 0; pass + 1 < stow_count; pass++) begin
				for (j = 0; j + 1 < stow_count - pass; j++) begin
					if (stow_ratio[j] < stow_ratio[j+1]) begin
						t_r = stow_ratio[j];
						t_w = stow_weight[j];
						stow_ratio[j] = stow_ratio[j+1];
						stow_weight[j] = stow_weight[j+1];
						stow_ratio[j+1] = t_r;
						stow_weight[j+1] = t_w;
					end
				end
			end
			// greedy walk, stop at the first item that does not fit
			total = 0;
			for (j = 0; j < stow_count; j++) begin
				nxt = total + stow_weight[j];
				if (nxt > model_capacity)
					break;
				total = nxt;
			end
			fill.packed_w = total[CapW-1:0];
			fill.dropped = stow_overflow;
			fill_q.push_back(fill);
			stow_count = 0;
			stow_overflow = 1'b0;
		end
	endfunction

	task automatic push_item(input logic [WeightW-1:0] w, input logic [ValueW-1:0] v,
			input logic last);
		load_step_t s;
		s.kind = STEP_ITEM;
		s.weight = w;
		s.value = v;
		s.last = last;
		s.cap = '0;
		load_q.push_back(s);
	endtask

	// wait for the block to go idle, then write capacity
	task automatic push_phase(input logic [CapW-1:0] cap);
		load_step_t s;
		s.kind = STEP_DRAIN;
		s.weight = '0;
		s.value = '0;
		s.last = 1'b0;
		s.cap = '0;
		load_q.push_back(s);
		s.kind = STEP_CAP;
		s.cap = cap;
		load_q.push_back(s);
	endtask

	// one well-formed set of random items in one of several value styles
	task automatic push_set(input int unsigned size);
		int unsigned        mode;
		int unsigned        i;
		int unsigned        k;
		int unsigned        prod;
		logic [WeightW-1:0] w;
		logic [ValueW-1:0]  v;
		mode = $urandom_range(3);
		for (i = 0; i < size; i++) begin
			case (mode)
				0: begin
					w = WeightW'($urandom);
					v = ValueW'($urandom);
				end
				1: begin
					// tiny weights: zeros and ratio ties are common
					w = WeightW'($urandom_range(7));
					v = ValueW'($urandom_range(40));
				end
				2: begin
					w = $urandom_range(1) ? {WeightW{1'b1}} : WeightW'(1);
					v = $urandom_range(1) ? {ValueW{1'b1}} : ValueW'($urandom);
				end
				default: begin
					// exact multiples give many equal ratios
					w = WeightW'($urandom_range(1, 2000));
					k = $urandom_range(30);
					prod = w * k;
					v = (prod > 65535) ? {ValueW{1'b1}} : ValueW'(prod);
				end
			endcase
			push_item(w, v, i + 1 == size);
		end
		random_items += size;
	endtask

	function automatic logic [CapW-1:0] pick_capacity();
		case ($urandom_range(4))
			0:       return '0;
			1:       return {CapW{1'b1}};
			2:       return CapW'($urandom);
			3:       return CapW'($urandom_range(300000));
			default: return CapW'($urandom_range(5000));
		endcase
	endfunction

	// driver: present load steps, hold a beat until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
			item_weight <= '0;
			item_value <= '0;
			last_item <= 1'b0;
			cfg_data <= '0;
			settle_cnt = 0;
		end else begin
			if (in_valid && !in_stall) begin
				spent_step = load_q.pop_front();
				beats_sent++;
			end
			if (cfg_valid && cfg_ready)
				spent_step = load_q.pop_front();
			if (in_valid && in_stall) begin
				// hold the stalled beat
			end else if (cfg_valid && !cfg_ready) begin
				// hold the pending write
			end else begin
				nxt_in_valid = 1'b0;
				nxt_cfg_valid = 1'b0;
				if (load_q.size() != 0) begin
					case (load_q[0].kind)
						STEP_ITEM: begin
							if ((beats_sent >= 600 && beats_sent < 800) ||
									$urandom_range(99) >= 23) begin
								item_weight <= load_q[0].weight;
								item_value <= load_q[0].value;
								last_item <= load_q[0].last;
								nxt_in_valid = 1'b1;
							end
						end
						STEP_CAP: begin
							cfg_data <= load_q[0].cap;
							nxt_cfg_valid = 1'b1;
						end
						default: begin
							// pause until every fill is back, then let the block settle
							if (fill_q.size() != 0) begin
								settle_cnt = 0;
							end else if (settle_cnt >= SETTLE) begin
								spent_step = load_q.pop_front();
								settle_cnt = 0;
							end else begin
								settle_cnt++;
							end
						end
					endcase
				end
				in_valid <= nxt_in_valid;
				cfg_valid <= nxt_cfg_valid;
			end
		end
	end

	// receiver stall, with a quiet stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= !(fills_seen >= 40 && fills_seen < 70) && ($urandom_range(99) < 23);
		end
	end

	// monitor: sample handshakes mid-cycle, they complete at the next rising edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				model_capacity = cfg_data;
			if (out_valid && !out_stall) begin
				fills_seen++;
				if (fill_q.size() == 0) begin
					report_mismatch($sformatf("unexpected fill beat packed_weight=%0d",
						packed_weight));
				end else begin
					if (packed_weight !== fill_q[0].packed_w)
						report_mismatch($sformatf("fill %0d packed_weight got %0d want %0d",
							fills_seen, packed_weight, fill_q[0].packed_w));
					if (items_dropped !== fill_q[0].dropped)
						report_mismatch($sformatf("fill %0d items_dropped got %b want %b",
							fills_seen, items_dropped, fill_q[0].dropped));
					void'(fill_q.pop_front());
				end
			end
			if (in_valid && !in_stall)
				stow_item(item_weight, item_value, last_item);
		end
	end

	initial begin
		int unsigned sets;
		int unsigned s;
		int unsigned r;

		// reset capacity of zero: a zero weight still fits
		push_item(16'd0, 16'd5, 1'b1);

		// full capacity: extreme fields, max ratio from zero weight, ratio tie
		push_phase({CapW{1'b1}});
		push_item(16'hFFFF, 16'hFFFF, 1'b0);
		push_item(16'h0001, 16'hFFFF, 1'b0);
		push_item(16'h0000, 16'h0000, 1'b0);
		push_item(16'hFFFF, 16'h0000, 1'b0);
		push_item(16'h0002, 16'h0007, 1'b1);

		// equal ratios keep input order, the walk stops at the first item that does not fit
		push_phase(24'd105);
		push_item(16'd40, 16'd80, 1'b0);
		push_item(16'd60, 16'd120, 1'b0);
		push_item(16'd10, 16'd5, 1'b0);
		push_item(16'd30, 16'd60, 1'b1);

		// exact fill on the largest weight alone
		push_phase(24'd65535);
		push_item(16'hFFFF, 16'h0001, 1'b0);
		push_item(16'h0001, 16'h0000, 1'b1);

		// a full store, one drop, and a drop that takes the last item with it
		push_phase(CapW'($urandom));
		push_set(MAX_ITEMS);
		push_set(MAX_ITEMS + 1);
		push_set(MAX_ITEMS + 3);

		// random phases of random sets
		while (random_items < ITEMS) begin
			push_phase(pick_capacity());
			sets = $urandom_range(1, 5);
			for (s = 0; s < sets; s++) begin
				r = $urandom_range(99);
				if (r < 3)
					push_set($urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6));
				else if (r < 20)
					push_set($urandom_range(9, 20));
				else
					push_set($urandom_range(1, 8));
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (load_q.size() != 0 || fill_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
